// File: design/rmsgate_pkg.sv
// Package for the RMS envelope noise gate and onset detector.
// Holds the controller-to-datapath command type, register indexes and fixed constants.
// No dependencies.
package rmsgate_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd2;

  localparam logic [16:0] OPEN_THR_RST = 17'd7864;
  localparam logic [16:0] CLOSE_THR_RST = 17'd3932;
  localparam logic [15:0] COOLDOWN_RST = 16'd4800;

  localparam logic [19:0] W_PREV = 20'd891290;
  localparam logic [19:0] W_RMS = 20'd157286;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [19:0] ROUND_Q20 = 20'd524288;

  localparam int QUO_W = 33;
  localparam int ROOT_W = 34;
  localparam int DIV_STEPS = 33;
  localparam int SQRT_STEPS = 17;
  localparam int STEP_CNT_W = 6;

  typedef struct packed {
    logic acc;
    logic div_load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic mul_prev;
    logic mul_rms;
    logic finish;
  } rmsgate_cmd_t;

endpackage

// File: design/rmsgate_ctrl.sv
// Controller state machine for the RMS envelope noise gate.
// Sequences accumulation, division, square root, smoothing and result write-out.
// Depends on rmsgate_pkg.
module rmsgate_ctrl
  import rmsgate_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_last_in_block,
  output logic         out_valid,
  input  logic         out_ready,
  output rmsgate_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV = 3'd2;
  localparam logic [2:0] ST_SQLD = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_MULP = 3'd5;
  localparam logic [2:0] ST_MULR = 3'd6;
  localparam logic [2:0] ST_FIN = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last_in_block) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt = STEP_CNT_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SQLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SQLD: begin
        cmd.sqrt_load = 1'b1;
        cnt_nxt = STEP_CNT_W'(SQRT_STEPS - 1);
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MULP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MULP: begin
        cmd.mul_prev = 1'b1;
        state_nxt = ST_MULR;
      end
      ST_MULR: begin
        cmd.mul_rms = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/rmsgate_dp.sv
// Datapath for the RMS envelope noise gate: accumulator, serial divider, serial
// square root, envelope smoothing, gate and cooldown state, result registers.
// Depends on rmsgate_pkg; driven by rmsgate_ctrl commands.
module rmsgate_dp
  import rmsgate_pkg::*;
#(
  parameter int MAX_BLOCK = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmsgate_cmd_t           cmd,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic [16:0]            out_level,
  output logic [16:0]            out_envelope,
  output logic                   out_gate_state,
  output logic                   out_onset_flag,
  output logic [6:0]             out_velocity
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int SH_L = (34 - 2 * SAMPLE_BITS > 0) ? 34 - 2 * SAMPLE_BITS : 0;
  localparam int SH_R = (2 * SAMPLE_BITS - 34 > 0) ? 2 * SAMPLE_BITS - 34 : 0;
  localparam int NUM_W = SUM_W + SH_L;
  localparam int DEN_W = CNT_W + SH_R + QUO_W;
  localparam int DIV_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int CD_W = (CNT_W > 16) ? CNT_W : 16;

  logic [16:0] open_thr_r, close_thr_r;
  logic [15:0] cd_len_r;

  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] count_r;
  logic [DIV_W-1:0] rem_r, dsr_r;
  logic [QUO_W-1:0] quo_r;
  logic [QUO_W-1:0] rad_r;
  logic [ROOT_W-1:0] res_r, bit_r;
  logic [37:0] prod_r;
  logic [16:0] env_r;
  logic gate_r;
  logic [15:0] cd_r;
  logic [6:0] vel_r;

  logic [16:0] lvl_o_r, env_o_r;
  logic gate_o_r, onset_o_r;
  logic [6:0] vel_o_r;

  logic [SAMPLE_BITS:0] mag;
  logic [2*SAMPLE_BITS+1:0] sq;
  logic div_ge;
  logic [ROOT_W-1:0] trial;
  logic sq_ge;
  logic [37:0] env_sum;
  logic [19:0] lvl_wide;
  logic [16:0] lvl;
  logic [CD_W-1:0] cd_ext, n_ext;
  logic [15:0] cd_dec;
  logic gate_nxt, onset;
  logic [23:0] vel_prod;
  logic [6:0] vel_new;

  assign mag = in_sample[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(1) << SAMPLE_BITS)
                                           - {1'b0, in_sample}
                                         : {1'b0, in_sample};
  assign sq = mag * mag;

  assign div_ge = rem_r >= dsr_r;
  assign trial = res_r + bit_r;
  assign sq_ge = ROOT_W'(rad_r) >= trial;

  assign env_sum = prod_r + 38'(W_RMS) * 38'(res_r[16:0]) + 38'(ROUND_Q20);

  assign lvl_wide = {env_r, 3'b000};
  assign lvl = (lvl_wide > 20'(ONE_Q16)) ? ONE_Q16 : lvl_wide[16:0];
  assign cd_ext = CD_W'(cd_r);
  assign n_ext = CD_W'(count_r);
  assign cd_dec = (cd_ext > n_ext) ? 16'(cd_ext - n_ext) : 16'd0;

  always_comb begin
    gate_nxt = gate_r;
    if (!gate_r && lvl >= open_thr_r) begin
      gate_nxt = 1'b1;
    end else if (gate_r && lvl <= close_thr_r) begin
      gate_nxt = 1'b0;
    end
  end

  assign onset = gate_nxt && !gate_r && (cd_dec == 16'd0);
  assign vel_prod = 24'd126 * 24'(lvl) + 24'd32768;
  assign vel_new = 7'(8'd1 + vel_prod[23:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_thr_r <= OPEN_THR_RST;
      close_thr_r <= CLOSE_THR_RST;
      cd_len_r <= COOLDOWN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPEN_THR: open_thr_r <= cfg_wdata;
        CFG_CLOSE_THR: close_thr_r <= cfg_wdata;
        CFG_COOLDOWN: cd_len_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      count_r <= '0;
      env_r <= '0;
      gate_r <= 1'b0;
      cd_r <= '0;
      vel_r <= '0;
    end else begin
      if (cmd.acc && (count_r < CNT_W'(MAX_BLOCK))) begin
        sum_r <= sum_r + SUM_W'(sq);
        count_r <= count_r + 1'b1;
      end
      if (cmd.mul_rms) begin
        env_r <= env_sum[36:20];
      end
      if (cmd.finish) begin
        gate_r <= gate_nxt;
        cd_r <= onset ? cd_len_r : cd_dec;
        if (onset) begin
          vel_r <= vel_new;
        end
        sum_r <= '0;
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= DIV_W'(sum_r) << SH_L;
      dsr_r <= DIV_W'(count_r) << (SH_R + QUO_W - 1);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[QUO_W-2:0], div_ge};
    end
    if (cmd.sqrt_load) begin
      rad_r <= quo_r;
      res_r <= '0;
      bit_r <= ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
    end else if (cmd.sqrt_step) begin
      if (sq_ge) begin
        rad_r <= QUO_W'(ROOT_W'(rad_r) - trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mul_prev) begin
      prod_r <= 38'(W_PREV) * 38'(env_r);
    end
    if (cmd.finish) begin
      lvl_o_r <= lvl;
      env_o_r <= env_r;
      gate_o_r <= gate_nxt;
      onset_o_r <= onset;
      vel_o_r <= onset ? vel_new : vel_r;
    end
  end

  assign out_level = lvl_o_r;
  assign out_envelope = env_o_r;
  assign out_gate_state = gate_o_r;
  assign out_onset_flag = onset_o_r;
  assign out_velocity = vel_o_r;

endmodule

// File: design/rms_envelope_gate_onset_detector.sv
// RMS envelope noise gate with onset detection, top level.
// Instantiates rmsgate_ctrl and rmsgate_dp; depends on rmsgate_pkg.
//
// Samples arrive on the in_ channel as valid/ready beats; a beat with
// in_last_in_block set closes a block. Non-final samples are taken as they
// come, in_ready staying high. A block end gives exactly one result beat
// on the out_ channel: level, envelope, gate state, onset flag and
// latest velocity. After the block-end beat come a divider load step,
// 33 restoring divider steps for the mean square, a root load step,
// 17 square-root steps, two multiply steps for the smoothing and a final
// step for the gate, cooldown and velocity update. During these steps
// in_ready is low.
// The result sits in an output register; the next block's samples are
// accepted while it waits. If a second result is ready before the first
// has been taken, the block holds it and stalls in_ready until out_ready.
// The cfg_ port writes open_threshold, close_threshold and cooldown_length
// (indexes 0, 1, 2); other indexes are ignored.
// Reset is synchronous, active low: registers return to their defaults,
// the envelope, cooldown and velocity clear and the gate closes.
module rms_envelope_gate_onset_detector
  import rmsgate_pkg::*;
#(
  parameter int MAX_BLOCK = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last_in_block,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [16:0]            out_level,
  output logic [16:0]            out_envelope,
  output logic                   out_gate_state,
  output logic                   out_onset_flag,
  output logic [6:0]             out_velocity,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  rmsgate_cmd_t cmd;

  rmsgate_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_last_in_block (in_last_in_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cmd              (cmd)
  );

  rmsgate_dp #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample      (in_sample),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_level      (out_level),
    .out_envelope   (out_envelope),
    .out_gate_state (out_gate_state),
    .out_onset_flag (out_onset_flag),
    .out_velocity   (out_velocity)
  );

endmodule

// File: design/rmsgate_chk.sv
// Port-level checker for the RMS envelope noise gate, bound to the top level.
// Depends only on the top-level ports.
module rmsgate_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_in_block,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_level,
  input logic [16:0] out_envelope,
  input logic        out_gate_state,
  input logic        out_onset_flag,
  input logic [6:0]  out_velocity
);

  // A held result beat keeps its level, envelope, velocity and onset flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_envelope)
      && $stable(out_velocity) && $stable(out_onset_flag))
    else $error("result beat changed while stalled");

  // The block is busy in the cycle after a block-end beat.
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_in_block |=> !in_ready)
    else $error("input taken straight after a block end");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level <= 17'd65536) && (out_envelope <= 17'd65536))
    else $error("level or envelope out of range");

  // An onset means the gate is open and a velocity has been recorded.
  a_onset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_onset_flag |-> out_gate_state && (out_velocity != 7'd0))
    else $error("onset without open gate or velocity");

endmodule

bind rms_envelope_gate_onset_detector rmsgate_chk u_rmsgate_chk (.*);
